// ===== rtl/swfd_pkg.sv =====
package swfd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int DLY_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;

    localparam logic [31:0] LCG_MUL   = 32'd1664525;
    localparam logic [31:0] LCG_INC   = 32'd1013904223;
    localparam logic [31:0] RAND_SEED = 32'h7BADB002;
    localparam logic [9:0]  WOW_COEF     = 10'd46;
    localparam logic [9:0]  FLUTTER_COEF = 10'd983;

    typedef logic [CFG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_WOW_INTERVAL     = 3'd0;
    localparam t_reg_idx REG_FLUTTER_INTERVAL = 3'd1;
    localparam t_reg_idx REG_WOW_SPAN         = 3'd2;
    localparam t_reg_idx REG_FLUTTER_SPAN     = 3'd3;
    localparam t_reg_idx REG_CENTER_DLY       = 3'd4;
    localparam t_reg_idx REG_JITTER_AMP       = 3'd5;
    localparam t_reg_idx REG_MOD_SCALE        = 3'd6;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
    } t_in;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } t_out;

    typedef struct packed {
        logic [19:0] wow_interval;
        logic [19:0] flutter_interval;
        logic [15:0] wow_span;
        logic [15:0] flutter_span;
        logic [21:0] center_dly;
        logic [15:0] jitter_amp;
        logic [15:0] mod_scale;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic [DLY_W-1:0]           dly_l;
        logic [DLY_W-1:0]           dly_r;
    } t_job;

    typedef enum logic [3:0] {
        F_IDLE, F_WOW, F_WGL, F_FLT, F_FGL, F_JIT, F_PRD, F_SUM, F_SCL, F_DLY, F_PUSH
    } t_fst;

    typedef enum logic [2:0] {
        B_CLR, B_IDLE, B_WR, B_RD0, B_RD1, B_CAP, B_OUT
    } t_bst;

    function automatic logic [31:0] lcg_next(input logic [31:0] x);
        return x * LCG_MUL + LCG_INC;
    endfunction

    // Bits 31..8 of the generator, offset to a signed Q1.23 value.
    function automatic logic signed [23:0] draw_val(input logic [31:0] x);
        return $signed({~x[31], x[30:8]});
    endfunction

    // One step of the first-order glide toward the goal, rounded half up.
    function automatic logic signed [23:0] glide(input logic signed [23:0] level,
                                                 input logic signed [23:0] goal,
                                                 input logic [9:0] coef);
        logic signed [24:0] d;
        logic signed [35:0] p;
        d = $signed({goal[23], goal}) - $signed({level[23], level});
        p = d * $signed({1'b0, coef});
        p = p + 36'sd32768;
        return level + $signed({{4{p[35]}}, p[35:16]});
    endfunction

endpackage

// ===== rtl/stereo_wow_flutter_delay.sv =====
// The modulation sequencer in the front part handles one transaction at a time; it accepts
// the next only after the last one has been pushed into the queue.
// The back part (store write, two interpolation reads, output) also works on one transaction
// at a time, in parallel with the front part.
// Reset (i_rst_n low, synchronous) restores registers, wander and random state, then runs a
// clearing pass over every entry of both sample stores while o_stall stays high.
module stereo_wow_flutter_delay import swfd_pkg::*; #(
    parameter int STORE_DEPTH = 16384
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in                   i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out                  o_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers. Writes are always taken; the user writes them only while
    // the block is idle, so no shadowing is needed.
    t_cfg r_cfg;

    logic w_start, w_front_busy, w_push, w_pop, w_full, w_empty, w_clearing;
    t_job w_job_in, w_job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wow_interval     <= 20'd105600;
            r_cfg.flutter_interval <= 20'd883;
            r_cfg.wow_span         <= 16'd16922;
            r_cfg.flutter_span     <= 16'd1679;
            r_cfg.center_dly       <= 22'd3123;
            r_cfg.jitter_amp       <= 16'd23;
            r_cfg.mod_scale        <= 16'd32768;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_WOW_INTERVAL:     r_cfg.wow_interval     <= i_cfg_data[19:0];
                REG_FLUTTER_INTERVAL: r_cfg.flutter_interval <= i_cfg_data[19:0];
                REG_WOW_SPAN:         r_cfg.wow_span         <= i_cfg_data[15:0];
                REG_FLUTTER_SPAN:     r_cfg.flutter_span     <= i_cfg_data[15:0];
                REG_CENTER_DLY:       r_cfg.center_dly       <= i_cfg_data[21:0];
                REG_JITTER_AMP:       r_cfg.jitter_amp       <= i_cfg_data[15:0];
                REG_MOD_SCALE:        r_cfg.mod_scale        <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // The front part takes one transaction at a time and stalls the input while it steps
    // through the wander, jitter and delay arithmetic. During the clearing pass the input
    // is stalled as well so that no sample lands in a store that is still being zeroed.
    assign o_stall = w_front_busy || w_clearing;
    assign w_start = i_valid && !o_stall;

    swfd_front #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_start (w_start),
        .i_data  (i_data),
        .o_busy  (w_front_busy),
        .o_push  (w_push),
        .o_job   (w_job_in),
        .i_full  (w_full)
    );

    // Two-entry queue between the delay computation and the store access, so that an
    // output stall holds the back part while the front part keeps working.
    swfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // The back part writes the sample pair, reads the two neighboring entries of each
    // channel through the registered memory port, interpolates and holds the result in
    // the output register until the transaction is taken.
    swfd_back #(
        .STORE_DEPTH(STORE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (w_job_out),
        .i_empty    (w_empty),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_stall    (i_stall)
    );

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> o_stall)
        else $error("input not stalled during store clearing");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue push while full");

    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue pop while empty");

endmodule

// ===== rtl/swfd_queue.sv =====
module swfd_queue import swfd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    input  logic i_pop,
    output t_job o_data,
    output logic o_full,
    output logic o_empty
);

    t_job       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_slot[r_rptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

endmodule

// ===== rtl/swfd_front.sv =====
module swfd_front import swfd_pkg::*; #(
    parameter int STORE_DEPTH = 16384
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_start,
    input  t_in  i_data,
    output logic o_busy,
    output logic o_push,
    output t_job o_job,
    input  logic i_full
);

    localparam int MAXD = (STORE_DEPTH - 2) * 256;

    t_fst r_state, n_state;

    t_in                r_smp;
    logic signed [23:0] r_wow_level, r_wow_goal, r_flt_level, r_flt_goal, r_jit;
    logic [19:0]        r_wow_left, r_flt_left;
    logic [31:0]        r_rand;
    logic signed [40:0] r_p1, r_p2, r_pj;
    logic signed [41:0] r_m;
    logic signed [58:0] r_ms;
    t_job               r_job;

    logic [31:0]        w_rand_nx;
    logic signed [58:0] w_ms_rnd;
    logic signed [40:0] w_pj_rnd;
    logic signed [24:0] w_mod, w_dl, w_dr;

    function automatic logic [DLY_W-1:0] clamp_dly(input logic signed [24:0] d);
        if (d < 0) begin
            return '0;
        end else if (d > $signed(25'(MAXD))) begin
            return DLY_W'(MAXD);
        end else begin
            return d[DLY_W-1:0];
        end
    endfunction

    assign w_rand_nx = lcg_next(r_rand);
    assign w_ms_rnd  = r_ms + (59'sd1 <<< 37);
    assign w_pj_rnd  = r_pj + (41'sd1 <<< 22);
    assign w_mod     = $signed({{4{w_ms_rnd[58]}}, w_ms_rnd[58:38]})
                     + $signed({{7{w_pj_rnd[40]}}, w_pj_rnd[40:23]});
    assign w_dl      = $signed({3'b0, i_cfg.center_dly}) + w_mod;
    assign w_dr      = $signed({3'b0, i_cfg.center_dly}) - w_mod;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE:  if (i_start) n_state = F_WOW;
            F_WOW:   n_state = F_WGL;
            F_WGL:   n_state = F_FLT;
            F_FLT:   n_state = F_FGL;
            F_FGL:   n_state = F_JIT;
            F_JIT:   n_state = F_PRD;
            F_PRD:   n_state = F_SUM;
            F_SUM:   n_state = F_SCL;
            F_SCL:   n_state = F_DLY;
            F_DLY:   n_state = F_PUSH;
            F_PUSH:  if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Wander and random state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wow_level <= '0;
            r_wow_goal  <= '0;
            r_wow_left  <= 20'd1;
            r_flt_level <= '0;
            r_flt_goal  <= '0;
            r_flt_left  <= 20'd1;
            r_rand      <= RAND_SEED;
        end else begin
            case (r_state)
                F_WOW: begin
                    if (r_wow_left == 20'd0) begin
                        r_rand     <= w_rand_nx;
                        r_wow_goal <= draw_val(w_rand_nx);
                        r_wow_left <= (i_cfg.wow_interval == 20'd0) ? 20'd0
                                    : i_cfg.wow_interval - 20'd1;
                    end else begin
                        r_wow_left <= r_wow_left - 20'd1;
                    end
                end
                F_WGL: r_wow_level <= glide(r_wow_level, r_wow_goal, WOW_COEF);
                F_FLT: begin
                    if (r_flt_left == 20'd0) begin
                        r_rand     <= w_rand_nx;
                        r_flt_goal <= draw_val(w_rand_nx);
                        r_flt_left <= (i_cfg.flutter_interval == 20'd0) ? 20'd0
                                    : i_cfg.flutter_interval - 20'd1;
                    end else begin
                        r_flt_left <= r_flt_left - 20'd1;
                    end
                end
                F_FGL: r_flt_level <= glide(r_flt_level, r_flt_goal, FLUTTER_COEF);
                F_JIT: r_rand <= w_rand_nx;
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: if (i_start) r_smp <= i_data;
            F_JIT:  r_jit <= draw_val(w_rand_nx);
            F_PRD: begin
                r_p1 <= r_wow_level * $signed({1'b0, i_cfg.wow_span});
                r_p2 <= r_flt_level * $signed({1'b0, i_cfg.flutter_span});
                r_pj <= r_jit * $signed({1'b0, i_cfg.jitter_amp});
            end
            F_SUM:  r_m  <= $signed({r_p1[40], r_p1}) + $signed({r_p2[40], r_p2});
            F_SCL:  r_ms <= r_m * $signed({1'b0, i_cfg.mod_scale});
            F_DLY: begin
                r_job.left  <= r_smp.left_in;
                r_job.right <= r_smp.right_in;
                r_job.dly_l <= clamp_dly(w_dl);
                r_job.dly_r <= clamp_dly(w_dr);
            end
            default: ;
        endcase
    end

    assign o_busy = (r_state != F_IDLE);
    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_job  = r_job;

endmodule

// ===== rtl/swfd_back.sv =====
module swfd_back import swfd_pkg::*; #(
    parameter int STORE_DEPTH = 16384
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_job,
    input  logic i_empty,
    output logic o_pop,
    output logic o_clearing,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);

    localparam int AW  = $clog2(STORE_DEPTH);
    localparam int RPW = 26;
    localparam logic [AW-1:0] LAST = AW'(STORE_DEPTH - 1);

    t_bst r_state, n_state;

    logic signed [SAMPLE_W-1:0] mem_l [STORE_DEPTH];
    logic signed [SAMPLE_W-1:0] mem_r [STORE_DEPTH];

    logic [AW-1:0]              r_clr_addr, r_wp, r_i0l, r_i0r;
    logic [7:0]                 r_fl, r_fr;
    t_job                       r_job;
    logic signed [SAMPLE_W-1:0] r_rd_l, r_rd_r, r_s0l, r_s0r, r_s1l, r_s1r;
    logic                       r_oval;
    t_out                       r_out;

    logic                       w_we, w_load;
    logic [AW-1:0]              w_wa, w_ra_l, w_ra_r;
    logic signed [SAMPLE_W-1:0] w_wd_l, w_wd_r;
    logic [RPW-1:0]             w_rp_l, w_rp_r;

    function automatic logic [AW-1:0] inc_addr(input logic [AW-1:0] a);
        return (a == LAST) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [RPW-1:0] rp_calc(input logic [AW-1:0] wp,
                                               input logic [DLY_W-1:0] dly);
        logic signed [RPW-1:0] rp;
        rp = $signed({{(RPW-AW-8){1'b0}}, wp, 8'd0}) - $signed({2'b0, dly});
        if (rp < 0) begin
            rp = rp + $signed(RPW'(STORE_DEPTH * 256));
        end
        return rp;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] interp(
            input logic signed [SAMPLE_W-1:0] s0,
            input logic signed [SAMPLE_W-1:0] s1,
            input logic [7:0] f);
        logic signed [25:0] acc;
        acc = s0 * $signed({1'b0, 9'd256 - {1'b0, f}}) + s1 * $signed({2'b0, f});
        acc = acc + 26'sd128;
        return acc[SAMPLE_W+7:8];
    endfunction

    assign w_rp_l = rp_calc(r_wp, r_job.dly_l);
    assign w_rp_r = rp_calc(r_wp, r_job.dly_r);
    assign w_load = (r_state == B_OUT) && (!r_oval || !i_stall);

    always_comb begin
        n_state = r_state;
        w_we    = 1'b0;
        w_wa    = r_wp;
        w_wd_l  = r_job.left;
        w_wd_r  = r_job.right;
        w_ra_l  = r_i0l;
        w_ra_r  = r_i0r;
        o_pop   = 1'b0;
        case (r_state)
            B_CLR: begin
                w_we   = 1'b1;
                w_wa   = r_clr_addr;
                w_wd_l = '0;
                w_wd_r = '0;
                if (r_clr_addr == LAST) n_state = B_IDLE;
            end
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = B_WR;
                end
            end
            B_WR: begin
                w_we    = 1'b1;
                n_state = B_RD0;
            end
            B_RD0: n_state = B_RD1;
            B_RD1: begin
                w_ra_l  = inc_addr(r_i0l);
                w_ra_r  = inc_addr(r_i0r);
                n_state = B_CAP;
            end
            B_CAP: n_state = B_OUT;
            B_OUT: if (w_load) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_l[w_wa] <= w_wd_l;
            mem_r[w_wa] <= w_wd_r;
        end
        r_rd_l <= mem_l[w_ra_l];
        r_rd_r <= mem_r[w_ra_r];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLR;
            r_clr_addr <= '0;
            r_wp       <= '0;
            r_oval     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CLR) begin
                r_clr_addr <= inc_addr(r_clr_addr);
            end
            if (w_load) begin
                r_wp <= inc_addr(r_wp);
            end
            r_oval <= w_load || (r_oval && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_state == B_WR) begin
            r_i0l <= w_rp_l[AW+7:8];
            r_i0r <= w_rp_r[AW+7:8];
            r_fl  <= w_rp_l[7:0];
            r_fr  <= w_rp_r[7:0];
        end
        if (r_state == B_RD1) begin
            r_s0l <= r_rd_l;
            r_s0r <= r_rd_r;
        end
        if (r_state == B_CAP) begin
            r_s1l <= r_rd_l;
            r_s1r <= r_rd_r;
        end
        if (w_load) begin
            r_out.left_out  <= interp(r_s0l, r_s1l, r_fl);
            r_out.right_out <= interp(r_s0r, r_s1r, r_fr);
        end
    end

    assign o_clearing = (r_state == B_CLR);
    assign o_valid    = r_oval;
    assign o_data     = r_out;

endmodule

// ===== tb/sv/stereo_wow_flutter_delay_tb.sv =====
module stereo_wow_flutter_delay_tb;
    import swfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16384;
    // The index one past the last register; a write there must change nothing.
    localparam t_reg_idx REG_UNUSED = 3'd7;
    // Extra wait after the last result is back, so that the block has fully drained.
    localparam int DRAIN_CYCLES = 24;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_in                   i_data;
    logic                  o_valid;
    logic                  i_stall;
    t_out                  o_data;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    stereo_wow_flutter_delay #(.STORE_DEPTH(DEPTH)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Shadow copy of the register file and of the delay line state.
    t_cfg        shadow_cfg;
    shortint     left_line [DEPTH];
    shortint     right_line [DEPTH];
    int unsigned wpos;
    int          wow_lvl, wow_tgt, flt_lvl, flt_tgt;
    int unsigned wow_cnt, flt_cnt;
    logic [31:0] lcg;

    // Expected output samples, oldest first, plus a per-transaction note that tells
    // whether a directed row carries a hand-written value to use instead.
    t_out exp_samples [$];
    bit   hand_flag [$];
    t_out hand_val [$];

    int errors;
    int n_sent, n_in, n_out, n_cfg, n_stalled_in;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR t=%0t output #%0d %s: got %0d, expected %0d",
                 $realtime, n_out, what, got, want);
        errors++;
    endtask

    function automatic void reset_shadow();
        shadow_cfg = '{wow_interval: 20'd105600, flutter_interval: 20'd883,
                       wow_span: 16'd16922, flutter_span: 16'd1679,
                       center_dly: 22'd3123, jitter_amp: 16'd23, mod_scale: 16'd32768};
        foreach (left_line[k]) begin
            left_line[k]  = 0;
            right_line[k] = 0;
        end
        wpos    = 0;
        wow_lvl = 0;
        wow_tgt = 0;
        flt_lvl = 0;
        flt_tgt = 0;
        wow_cnt = 1;
        flt_cnt = 1;
        lcg     = RAND_SEED;
    endfunction

    function automatic void shadow_write(input t_reg_idx idx, input logic [21:0] val);
        case (idx)
            REG_WOW_INTERVAL:     shadow_cfg.wow_interval     = val[19:0];
            REG_FLUTTER_INTERVAL: shadow_cfg.flutter_interval = val[19:0];
            REG_WOW_SPAN:         shadow_cfg.wow_span         = val[15:0];
            REG_FLUTTER_SPAN:     shadow_cfg.flutter_span     = val[15:0];
            REG_CENTER_DLY:       shadow_cfg.center_dly       = val;
            REG_JITTER_AMP:       shadow_cfg.jitter_amp       = val[15:0];
            REG_MOD_SCALE:        shadow_cfg.mod_scale        = val[15:0];
            default: ;
        endcase
    endfunction

    // Advance the generator and return bits 31..8 as a signed Q1.23 value.
    function automatic int next_rand();
        lcg = lcg * 32'd1664525 + 32'd1013904223;
        return int'({8'd0, lcg[31:8]}) - 32'h0080_0000;
    endfunction

    function automatic int approach(input int lvl, input int tgt, input longint k);
        longint diff;
        diff = longint'(tgt) - longint'(lvl);
        return lvl + int'((diff * k + 32768) >>> 16);
    endfunction

    // Interpolated read from one line at a Q.8 delay, clamped to the usable range.
    function automatic shortint tap(input bit right_ch, input longint dly);
        longint      maxd, rp, acc, a, b;
        int unsigned i0, i1, frac;
        maxd = longint'(DEPTH - 2) * 256;
        if (dly < 0)    dly = 0;
        if (dly > maxd) dly = maxd;
        rp = longint'(wpos) * 256 - dly;
        if (rp < 0) rp += longint'(DEPTH) * 256;
        i0   = int'(rp >>> 8) % DEPTH;
        i1   = (i0 + 1) % DEPTH;
        frac = int'(rp & 255);
        a    = right_ch ? right_line[i0] : left_line[i0];
        b    = right_ch ? right_line[i1] : left_line[i1];
        acc  = a * (256 - frac) + b * frac;
        return shortint'((acc + 128) >>> 8);
    endfunction

    // Works out the delayed stereo pair for one input pair and updates the shadow state.
    function automatic t_out delay_pair(input t_in smp);
        int     jit;
        longint m, modv, dl, dr;
        t_out   r;
        if (wow_cnt == 0) begin
            wow_cnt = (shadow_cfg.wow_interval != 0) ? shadow_cfg.wow_interval : 1;
            wow_tgt = next_rand();
        end
        wow_cnt = (wow_cnt - 1) & 20'hFFFFF;
        wow_lvl = approach(wow_lvl, wow_tgt, 46);
        if (flt_cnt == 0) begin
            flt_cnt = (shadow_cfg.flutter_interval != 0) ? shadow_cfg.flutter_interval : 1;
            flt_tgt = next_rand();
        end
        flt_cnt = (flt_cnt - 1) & 20'hFFFFF;
        flt_lvl = approach(flt_lvl, flt_tgt, 983);
        jit = next_rand();
        m = longint'(wow_lvl) * longint'(shadow_cfg.wow_span)
          + longint'(flt_lvl) * longint'(shadow_cfg.flutter_span);
        m = m * longint'(shadow_cfg.mod_scale);
        modv = (m + (64'sd1 <<< 37)) >>> 38;
        modv += (longint'(jit) * longint'(shadow_cfg.jitter_amp) + (64'sd1 <<< 22)) >>> 23;
        dl = longint'(shadow_cfg.center_dly) + modv;
        dr = longint'(shadow_cfg.center_dly) - modv;
        left_line[wpos]  = smp.left_in;
        right_line[wpos] = smp.right_in;
        r.left_out  = tap(1'b0, dl);
        r.right_out = tap(1'b1, dr);
        wpos = (wpos + 1) % DEPTH;
        return r;
    endfunction

    // Input side: every accepted transaction is run through the shadow model at once,
    // so its result always reflects the registers that were in force when it went in.
    always @(posedge i_clk) begin
        t_out p;
        if (i_rst_n && i_valid && !o_stall) begin
            p = delay_pair(i_data);
            if (hand_flag.size() != 0 && hand_flag.pop_front()) p = hand_val.pop_front();
            exp_samples.push_back(p);
            n_in++;
        end
        if (i_rst_n && i_valid && o_stall) n_stalled_in++;
    end

    // Output side: compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (exp_samples.size() == 0) begin
                $display("ERROR t=%0t output with no expectation pending", $realtime);
                errors++;
            end else begin
                w = exp_samples.pop_front();
                if (o_data.left_out !== w.left_out)
                    report_mismatch("left_out", o_data.left_out, w.left_out);
                if (o_data.right_out !== w.right_out)
                    report_mismatch("right_out", o_data.right_out, w.right_out);
            end
            n_out++;
        end
    end

    // Receiver back-pressure. A long hold is requested through hold_left and counted
    // down here, independent of the sender.
    int hold_left;
    bit rx_busy_on;
    always @(negedge i_clk) begin
        int burst, r;
        if (hold_left > 0) begin
            i_stall = 1'b1;
            hold_left--;
        end else if (!rx_busy_on) begin
            i_stall = 1'b0;
        end else if (burst > 0) begin
            burst--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                i_stall = 1'b0;
                burst   = $urandom_range(0, 6);
            end else if (r < 96) begin
                i_stall = 1'b1;
                burst   = $urandom_range(0, 3);
            end else begin
                i_stall = 1'b1;
                burst   = $urandom_range(20, 60);
            end
        end
    end

    bit tx_gaps_on;

    // Offers one sample pair and holds it until the block takes it.
    task automatic send_pair(input t_in d, input bit hand, input t_out hv);
        int r;
        if (tx_gaps_on) begin
            r = $urandom_range(0, 99);
            if (r >= 97)      repeat ($urandom_range(20, 60)) @(negedge i_clk);
            else if (r >= 70) repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        hand_flag.push_back(hand);
        if (hand) hand_val.push_back(hv);
        i_data  = d;
        i_valid = 1'b1;
        n_sent++;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Waits until every expected result is back and the pipeline has drained.
    task automatic wait_idle();
        while (exp_samples.size() != 0 || n_in != n_sent) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [21:0] val);
        i_cfg_index = idx;
        i_cfg_data  = val;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_write(idx, val);
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic write_all(input t_cfg c);
        write_reg(REG_WOW_INTERVAL, CFG_DATA_W'(c.wow_interval));
        write_reg(REG_FLUTTER_INTERVAL, CFG_DATA_W'(c.flutter_interval));
        write_reg(REG_WOW_SPAN, CFG_DATA_W'(c.wow_span));
        write_reg(REG_FLUTTER_SPAN, CFG_DATA_W'(c.flutter_span));
        write_reg(REG_CENTER_DLY, c.center_dly);
        write_reg(REG_JITTER_AMP, CFG_DATA_W'(c.jitter_amp));
        write_reg(REG_MOD_SCALE, CFG_DATA_W'(c.mod_scale));
    endtask

    // Directed stimulus. The first rows follow reset: the default delay is about twelve
    // samples, so they read the cleared store and must come out as silence. The rest run
    // with all modulation off and zero base delay, where the output is the input itself.
    typedef struct {
        bit   zero_mod_first;
        bit   hand;
        t_in  d;
    } t_row;

    t_row plan [] = '{
        '{0, 1, '{16'sh7FFF, -16'sh8000}},
        '{0, 1, '{-16'sh8000, 16'sh7FFF}},
        '{0, 1, '{16'sh5555, 16'shAAAA}},
        '{0, 1, '{-16'sh0001, 16'sh0001}},
        '{1, 1, '{16'sh7FFF, 16'sh7FFF}},
        '{0, 1, '{-16'sh8000, -16'sh8000}},
        '{0, 1, '{16'sh0000, 16'sh0000}},
        '{0, 1, '{-16'sh0001, -16'sh0001}},
        '{0, 1, '{16'sh0001, -16'sh7FFF}},
        '{0, 1, '{16'sh5555, 16'shAAAA}},
        '{0, 1, '{16'shAAAA, 16'sh5555}},
        '{0, 1, '{16'sh7FFF, -16'sh8000}},
        '{0, 1, '{16'sh00FF, 16'shFF00}},
        '{0, 1, '{16'sh1234, -16'sh1234}}
    };

    function automatic t_in rand_pair();
        t_in d;
        int  r;
        d = t_in'($urandom);
        r = $urandom_range(0, 19);
        if (r == 0) d.left_in  = 16'sh7FFF;
        if (r == 1) d.left_in  = -16'sh8000;
        if (r == 2) d.right_in = 16'sh7FFF;
        if (r == 3) d.right_in = -16'sh8000;
        return d;
    endfunction

    function automatic t_cfg rand_cfg(input int kind);
        t_cfg c;
        c.wow_interval     = 20'($urandom_range(0, 60));
        c.flutter_interval = 20'($urandom_range(0, 20));
        c.wow_span         = 16'($urandom);
        c.flutter_span     = 16'($urandom);
        c.center_dly       = 22'($urandom_range(0, 4193792));
        c.jitter_amp       = 16'($urandom);
        c.mod_scale        = 16'($urandom_range(0, 32768));
        case (kind)
            // Zero intervals, full depths, scale past unity and zero base delay:
            // one of the left and right delays runs well below zero and must clamp.
            1: begin
                c.wow_interval     = '0;
                c.flutter_interval = '0;
                c.wow_span         = 16'hFFFF;
                c.flutter_span     = 16'hFFFF;
                c.jitter_amp       = 16'hFFFF;
                c.mod_scale        = 16'hFFFF;
                c.center_dly       = '0;
            end
            // Longest intervals and the largest base delay, right at the far-end clamp limit.
            2: begin
                c.wow_interval     = 20'hFFFFF;
                c.flutter_interval = 20'hFFFFF;
                c.center_dly       = 22'd4193792;
                c.mod_scale        = 16'd32768;
            end
            // No modulation at all and a short fractional delay.
            3: begin
                c.mod_scale  = '0;
                c.jitter_amp = '0;
                c.center_dly = 22'($urandom_range(0, 4000));
            end
            // Short delays so that recent samples come back with visible interpolation.
            4: begin
                c.wow_interval     = 20'd1;
                c.flutter_interval = 20'd1;
                c.center_dly       = 22'($urandom_range(256, 20000));
                c.mod_scale        = 16'($urandom);
            end
            default: ;
        endcase
        return c;
    endfunction

    initial begin
        t_cfg zero_mod;
        int   n_random;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        hold_left   = 0;
        rx_busy_on  = 1'b0;
        tx_gaps_on  = 1'b0;
        errors      = 0;
        reset_shadow();
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        zero_mod = '{wow_interval: 20'd5, flutter_interval: 20'd3, wow_span: 16'd0,
                     flutter_span: 16'd0, center_dly: 22'd0, jitter_amp: 16'd0,
                     mod_scale: 16'd32768};

        // Directed part.
        foreach (plan[k]) begin
            if (plan[k].zero_mod_first) begin
                wait_idle();
                write_all(zero_mod);
            end
            send_pair(plan[k].d, plan[k].hand,
                      plan[k].zero_mod_first || k >= 4 ?
                      t_out'({plan[k].d.left_in, plan[k].d.right_in}) : t_out'('0));
        end

        // Random part: one register setting per phase, with idle gaps on both sides except in the
        // first phase, which runs back to back, and in the long-hold phase, where the sender has none.
        for (int ph = 0; ph < 7; ph++) begin
            wait_idle();
            write_all(rand_cfg(ph % 5));
            if (ph == 3) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
            tx_gaps_on = (ph != 0);
            rx_busy_on = (ph != 0);
            n_random = 75;
            if (ph == 5) begin
                // The receiver holds off for a long stretch while the sender keeps
                // offering, so the block fills and has to stall its input.
                hold_left = 300;
                tx_gaps_on = 1'b0;
            end
            for (int k = 0; k < n_random; k++)
                send_pair(rand_pair(), 1'b0, '0);
        end

        wait_idle();
        $display("Covered %0d input and %0d output transactions over %0d register writes;",
                 n_in, n_out, n_cfg);
        $display("input held off on %0d cycles, including a long output hold.", n_stalled_in);
        if (errors == 0) begin
            $display("stereo_wow_flutter_delay: match");
        end else begin
            $display("stereo_wow_flutter_delay: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out with %0d results outstanding.", exp_samples.size());
        $display("stereo_wow_flutter_delay: mismatch");
        $finish;
    end

endmodule
